@@ rtl/multilevel_priority_rr_scheduler_defines.svh @@
// Assertion macros shared by the checker.
`ifndef MULTILEVEL_PRIORITY_RR_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_PRIORITY_RR_SCHEDULER_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define MPRR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal that must be high at every edge outside reset.
`define MPRR_ASSERT_HIGH(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) sig == 1'b1) else $error(msg);

`endif

@@ rtl/mprr_pkg.sv @@
`default_nettype none
package mprr_pkg;
    localparam int MaxTasks = 16;
    localparam int IdxW = $clog2(MaxTasks);
    localparam int CntW = $clog2(MaxTasks + 1);

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [0:0] ADDR_QUANTUM = 1'b0;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [15:0] rem;
    } task_t;

    typedef struct packed {
        logic        op;
        task_t       tsk;
    } cmd_t;

    typedef struct packed {
        logic       busy;
        logic [7:0] id;
        logic       fin;
        logic       ovf;
    } res_t;
endpackage
`default_nettype wire

@@ rtl/multilevel_priority_rr_scheduler.sv @@
`default_nettype none
// Channel   | Handshake          | Payload
// command   | start / busy       | op, task_id, priority_req, burst
// result    | done strobe        | busy_res, running_task, finished, overflow
// register  | APB write/read     | quantum_length at address 0
// A command is written into a two-entry queue at its transfer edge and the
// scheduler core executes it at the next edge, one command per core cycle.
// A tick result is registered when the core executes it and is driven with done in
// the following cycle, so transfers can follow back to back.
// busy stays low because the core drains the queue every cycle; results cannot
// be stalled. Reset clears the queues, the running task and the overflow flag.
module multilevel_priority_rr_scheduler
    import mprr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [7:0]  task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [15:0] burst,
    output logic             done,
    output logic             busy_res,
    output logic [7:0]       running_task,
    output logic             finished,
    output logic             overflow
);
    logic [7:0] qlen_reg, qlen_next;
    logic       q_valid, q_pop;
    cmd_t       q_cmd;
    res_t       res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_QUANTUM) ? {24'd0, qlen_reg} : 32'd0;

    always_comb
    begin
        qlen_next = qlen_reg;
        if (psel && penable && pwrite && paddr == ADDR_QUANTUM)
        begin
            qlen_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= 8'd2;
        end
        else
        begin
            qlen_reg <= qlen_next;
        end
    end

    mprr_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .task_id(task_id),
        .priority_req(priority_req), .burst(burst), .busy(busy),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    mprr_back u_back (
        .clk(clk), .rst_n(rst_n), .quantum_length(qlen_reg), .q_valid(q_valid),
        .q_cmd(q_cmd), .q_pop(q_pop), .res_valid(done), .res(res)
    );

    assign busy_res     = res.busy;
    assign running_task = res.id;
    assign finished     = res.fin;
    assign overflow     = res.ovf;
endmodule
`default_nettype wire

@@ rtl/mprr_front.sv @@
`default_nettype none
// Accepts commands and parks them in a two-entry queue for the back end.
module mprr_front
    import mprr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        op,
    input  wire logic [7:0]  task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [15:0] burst,
    output logic             busy,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_pop
);
    cmd_t       ent_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = ent_reg[rd_reg];

    always_comb
    begin
        rd_next  = rd_reg ^ q_pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= '{op: op, tsk: '{id: task_id, pri: priority_req, rem: burst}};
        end
    end
endmodule
`default_nettype wire

@@ rtl/mprr_back.sv @@
`default_nettype none
// Sorted priority array, round-robin ring and the running task; one command
// per cycle.
module mprr_back
    import mprr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] quantum_length,
    input  wire logic       q_valid,
    input  cmd_t            q_cmd,
    output logic            q_pop,
    output logic            res_valid,
    output res_t            res
);
    typedef enum logic [1:0] {MODE_IDLE, MODE_PRIO, MODE_RR} mode_t;

    task_t            pq_reg [MaxTasks];
    task_t            pq_next [MaxTasks];
    logic [CntW-1:0]  pcnt_reg, pcnt_next;
    task_t            rr_reg [MaxTasks];
    logic [IdxW-1:0]  rhead_reg, rhead_next;
    logic [CntW-1:0]  rcnt_reg, rcnt_next;
    task_t            cur_reg, cur_next;
    mode_t            mode_reg, mode_next;
    logic [7:0]       qleft_reg, qleft_next;
    logic             ovf_reg, ovf_next;
    logic             rv_reg, rv_next;
    res_t             res_reg, res_next;
    logic             rr_we;
    task_t            rr_wd;
    logic [IdxW-1:0]  rr_wa;
    logic             pop_p;
    logic             ins;
    logic [MaxTasks-1:0] lt;
    logic             rr_full;

    assign q_pop     = q_valid;
    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign rr_full   = (rcnt_reg == CntW'(MaxTasks));

    // Position compare for a sorted insert: new task goes before entry i.
    always_comb
    begin
        for (int i = 0; i < MaxTasks; i++)
        begin
            lt[i] = q_cmd.tsk.pri < pq_reg[i].pri;
        end
    end

    always_comb
    begin
        pcnt_next  = pcnt_reg;
        rhead_next = rhead_reg;
        rcnt_next  = rcnt_reg;
        cur_next   = cur_reg;
        mode_next  = mode_reg;
        qleft_next = qleft_reg;
        ovf_next   = ovf_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        rr_we      = 1'b0;
        rr_wd      = cur_reg;
        rr_wa      = rhead_reg + rcnt_reg[IdxW-1:0];
        pop_p      = 1'b0;
        ins        = 1'b0;
        for (int i = 0; i < MaxTasks; i++)
        begin
            pq_next[i] = pq_reg[i];
        end

        if (q_valid && q_cmd.op == OP_ARRIVE)
        begin
            if (pcnt_reg == CntW'(MaxTasks))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ins = 1'b1;
                pcnt_next = pcnt_reg + 1'b1;
                for (int i = 0; i < MaxTasks; i++)
                begin
                    if (CntW'(i) < pcnt_reg && lt[i])
                    begin
                        if (i == 0 || !(lt[(i == 0) ? 0 : i-1])
                            || CntW'(i) == 0)
                        begin
                            pq_next[i] = q_cmd.tsk;
                        end
                        else
                        begin
                            pq_next[i] = pq_reg[(i == 0) ? 0 : i-1];
                        end
                    end
                    else if (CntW'(i) == pcnt_reg)
                    begin
                        if (i != 0 && lt[(i == 0) ? 0 : i-1])
                        begin
                            pq_next[i] = pq_reg[(i == 0) ? 0 : i-1];
                        end
                        else
                        begin
                            pq_next[i] = q_cmd.tsk;
                        end
                    end
                end
            end
        end
        else if (q_valid)
        begin
            rv_next = 1'b1;
            unique case (mode_reg)
                MODE_PRIO:
                begin
                    if (pcnt_reg != '0 && pq_reg[0].pri < cur_reg.pri)
                    begin
                        rr_we = 1'b1;
                        pop_p = 1'b1;
                    end
                end
                MODE_RR:
                begin
                    if (pcnt_reg != '0)
                    begin
                        rr_we = 1'b1;
                        pop_p = 1'b1;
                        mode_next = MODE_PRIO;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (pcnt_reg != '0)
                    begin
                        pop_p = 1'b1;
                        mode_next = MODE_PRIO;
                    end
                    else if (rcnt_reg != '0)
                    begin
                        cur_next   = rr_reg[rhead_reg];
                        cur_next.pri = 8'd0;
                        rhead_next = rhead_reg + 1'b1;
                        rcnt_next  = rcnt_reg - 1'b1;
                        mode_next  = MODE_RR;
                        qleft_next = quantum_length;
                    end
                end
            endcase
            if (rr_we)
            begin
                if (rr_full)
                begin
                    rr_we = 1'b0;
                    ovf_next = 1'b1;
                end
                else
                begin
                    rcnt_next = rcnt_next + 1'b1;
                end
            end
            if (pop_p)
            begin
                cur_next  = pq_reg[0];
                pcnt_next = pcnt_reg - 1'b1;
                for (int i = 0; i < MaxTasks - 1; i++)
                begin
                    pq_next[i] = pq_reg[i+1];
                end
            end
            res_next = '{busy: 1'b0, id: 8'd0, fin: 1'b0, ovf: 1'b0};
            if (mode_next != MODE_IDLE)
            begin
                res_next.busy = 1'b1;
                res_next.id   = cur_next.id;
                if (cur_next.rem <= 16'd1)
                begin
                    res_next.fin = 1'b1;
                    cur_next.rem = 16'd0;
                    mode_next    = MODE_IDLE;
                end
                else
                begin
                    cur_next.rem = cur_next.rem - 16'd1;
                    if (mode_next == MODE_RR)
                    begin
                        if (qleft_next <= 8'd1)
                        begin
                            qleft_next = 8'd0;
                            mode_next  = MODE_IDLE;
                            // Expiry requeue; a demotion can't happen in the same tick.
                            if (rcnt_next == CntW'(MaxTasks))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                rr_we = 1'b1;
                                rr_wd = cur_next;
                                rr_wa = rhead_next + rcnt_next[IdxW-1:0];
                                rcnt_next = rcnt_next + 1'b1;
                            end
                        end
                        else
                        begin
                            qleft_next = qleft_next - 8'd1;
                        end
                    end
                end
            end
            res_next.ovf = ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg  <= '0;
            rhead_reg <= '0;
            rcnt_reg  <= '0;
            cur_reg   <= '0;
            mode_reg  <= MODE_IDLE;
            qleft_reg <= '0;
            ovf_reg   <= 1'b0;
            rv_reg    <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            pcnt_reg  <= pcnt_next;
            rhead_reg <= rhead_next;
            rcnt_reg  <= rcnt_next;
            cur_reg   <= cur_next;
            mode_reg  <= mode_next;
            qleft_reg <= qleft_next;
            ovf_reg   <= ovf_next;
            rv_reg    <= rv_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins || pop_p)
        begin
            for (int i = 0; i < MaxTasks; i++)
            begin
                pq_reg[i] <= pq_next[i];
            end
        end
        if (rr_we)
        begin
            rr_reg[rr_wa] <= rr_wd;
        end
    end
endmodule
`default_nettype wire

@@ rtl/mprr_checker.sv @@
`default_nettype none
`include "multilevel_priority_rr_scheduler_defines.svh"
module mprr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       done,
    input wire logic       busy_res,
    input wire logic [7:0] running_task,
    input wire logic       finished,
    input wire logic       overflow,
    input wire logic       pready
);
    `MPRR_ASSERT(a_fin_busy, clk, rst_n, done && finished |-> busy_res, "finished without busy")
    `MPRR_ASSERT(a_idle_id, clk, rst_n, done && !busy_res |-> running_task == 8'd0, "idle id nonzero")
    `MPRR_ASSERT(a_ovf_sticky, clk, rst_n, done && overflow |=> !done || overflow, "overflow cleared")
    `MPRR_ASSERT_HIGH(a_pready, clk, rst_n, pready, "pready low")
endmodule

bind multilevel_priority_rr_scheduler mprr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .done(done), .busy_res(busy_res),
    .running_task(running_task), .finished(finished), .overflow(overflow),
    .pready(pready)
);
`default_nettype wire
